### src/fccw_pkg.sv
// Shared types and constants of the FAT cluster chain walker.
package fccw_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] STAT_MORE    = 3'd0;
  localparam logic [2:0] STAT_END     = 3'd1;
  localparam logic [2:0] STAT_BAD     = 3'd2;
  localparam logic [2:0] STAT_INVALID = 3'd3;
  localparam logic [2:0] STAT_FULL    = 3'd4;
  localparam logic [2:0] STAT_BEYOND  = 3'd5;
  localparam logic [2:0] STAT_IDLE    = 3'd6;

  localparam logic [1:0] REG_FAT_MODE     = 2'd0;
  localparam logic [1:0] REG_CLUSTER_BASE = 2'd1;
  localparam logic [1:0] REG_SECTORS      = 2'd2;
  localparam logic [1:0] REG_WINDOW       = 2'd3;

  localparam logic [31:0] FAT16_BAD = 32'h0000_fff7;
  localparam logic [31:0] FAT16_EOC = 32'h0000_fff8;
  localparam logic [31:0] FAT32_BAD = 32'h0fff_fff7;
  localparam logic [31:0] FAT32_EOC = 32'h0fff_fff8;
  localparam logic [31:0] LINK_MIN  = 32'd2;
  localparam logic [10:0] DONE_MAX  = 11'h7ff;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] index;
    logic [31:0] value;
  } queue_entry_t;

  typedef struct packed {
    logic        fat_mode;
    logic [31:0] cluster_base;
    logic [7:0]  sectors_per_cluster;
    logic [10:0] window_sectors;
  } cfg_t;

endpackage

### src/fccw_ifs.sv
// Request and response channel interfaces of the chain walker.
interface fccw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] entry_index;
  logic [31:0] entry_value;
  logic [31:0] start_cluster;

  modport source (output valid, cmd, entry_index, entry_value, start_cluster, input ready);
  modport sink (input valid, cmd, entry_index, entry_value, start_cluster, output ready);
endinterface

interface fccw_rsp_if;
  logic        valid;
  logic        ready;
  logic [39:0] sector_addr;
  logic [7:0]  sector_count;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, sector_addr, sector_count, status, last, input ready);
  modport sink (input valid, sector_addr, sector_count, status, last, output ready);
endinterface

### src/fccw_front.sv
// Front end: accepts request transactions and queues the ones that do work.
module fccw_front #(
  parameter int TABLE_ENTRIES = 4096
) (
  fccw_req_if.sink             request,
  input  logic                 full,
  output logic                 push,
  output fccw_pkg::queue_entry_t push_data
);
  import fccw_pkg::*;

  logic keep;

  always_comb begin
    keep = 1'b0;
    push_data.op = request.cmd;
    push_data.index = request.entry_index;
    push_data.value = request.start_cluster;
    case (request.cmd)
      CMD_LOAD: begin
        keep = 32'(request.entry_index) < 32'(TABLE_ENTRIES);
        push_data.value = request.entry_value;
      end
      CMD_START: keep = 1'b1;
      CMD_STEP: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign request.ready = !full;
  assign push = request.valid && !full && keep;

endmodule

### src/fccw_queue.sv
// Short queue between the front end and the walk engine.
module fccw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fccw_pkg::queue_entry_t push_data,
  input  logic                   pop,
  output fccw_pkg::queue_entry_t pop_data,
  output logic                   full,
  output logic                   empty
);
  import fccw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  queue_entry_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/fccw_back.sv
// Walk engine: link table, walk state, and the registered response.
module fccw_back #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fccw_pkg::cfg_t         cfg,
  input  logic                   empty,
  input  fccw_pkg::queue_entry_t pop_data,
  output logic                   pop,
  fccw_rsp_if.source             response
);
  import fccw_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic S_POP  = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic [31:0] link_mem [TABLE_ENTRIES];
  logic [31:0] rdata;

  logic        state;
  logic [31:0] cur_cluster;
  logic [10:0] sectors_done;
  logic        walk_active;
  logic [31:0] eval_cluster;
  logic        eval_idle;
  logic [39:0] product;

  logic        out_valid;
  logic [39:0] out_addr;
  logic [7:0]  out_count;
  logic [2:0]  out_status;
  logic        out_last;

  logic [31:0]      walk_cluster;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic             eval_fire;
  logic [11:0]      done_sum;
  logic [10:0]      done_sat;
  logic [31:0]      link;
  logic [2:0]       status_next;
  logic             beyond;

  assign pop = state == S_POP && !empty;
  assign mem_we = pop && pop_data.op == CMD_LOAD;
  assign walk_cluster = (pop_data.op == CMD_START) ? pop_data.value : cur_cluster;
  assign rd_addr = IDX_W'(walk_cluster);
  assign eval_fire = state == S_EVAL && (!out_valid || response.ready);

  assign done_sum = {1'b0, sectors_done} + 12'(cfg.sectors_per_cluster);
  assign done_sat = done_sum[11] ? DONE_MAX : done_sum[10:0];
  assign link = cfg.fat_mode ? rdata : {16'b0, rdata[15:0]};
  assign beyond = {1'b0, eval_cluster} >= 33'(TABLE_ENTRIES);

  always_comb begin
    if (beyond) begin
      status_next = STAT_BEYOND;
    end else if (link < LINK_MIN) begin
      status_next = STAT_INVALID;
    end else if (link == (cfg.fat_mode ? FAT32_BAD : FAT16_BAD)) begin
      status_next = STAT_BAD;
    end else if (link >= (cfg.fat_mode ? FAT32_EOC : FAT16_EOC)) begin
      status_next = STAT_END;
    end else if (done_sat >= cfg.window_sectors) begin
      status_next = STAT_FULL;
    end else begin
      status_next = STAT_MORE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[IDX_W'(pop_data.index)] <= pop_data.value;
    end
    if (pop) begin
      rdata <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      eval_cluster <= walk_cluster;
      eval_idle <= pop_data.op == CMD_STEP && !walk_active;
      product <= 40'(cfg.sectors_per_cluster) * 40'(walk_cluster);
    end
    if (eval_fire) begin
      if (eval_idle) begin
        out_addr <= '0;
        out_count <= '0;
        out_status <= STAT_IDLE;
        out_last <= 1'b0;
      end else begin
        out_addr <= product + 40'(cfg.cluster_base);
        out_count <= cfg.sectors_per_cluster;
        out_status <= status_next;
        out_last <= status_next != STAT_MORE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_POP;
      cur_cluster <= '0;
      sectors_done <= '0;
      walk_active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_POP: begin
          if (pop && pop_data.op != CMD_LOAD) begin
            state <= S_EVAL;
            if (pop_data.op == CMD_START) begin
              cur_cluster <= pop_data.value;
              sectors_done <= '0;
              walk_active <= 1'b1;
            end
          end
        end
        S_EVAL: begin
          if (eval_fire) begin
            state <= S_POP;
            if (!eval_idle) begin
              sectors_done <= done_sat;
              if (status_next == STAT_MORE) begin
                cur_cluster <= link;
              end else begin
                walk_active <= 1'b0;
              end
            end
          end
        end
        default: state <= S_POP;
      endcase
      if (eval_fire) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign response.valid = out_valid;
  assign response.sector_addr = out_addr;
  assign response.sector_count = out_count;
  assign response.status = out_status;
  assign response.last = out_last;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == STAT_IDLE) |-> (out_count == '0 && !out_last && out_addr == '0))
    else $error("idle response carries a read");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != STAT_IDLE) |-> (out_last == (out_status != STAT_MORE)))
    else $error("last does not match status");

  a_walk_to_eval: assert property (@(posedge clk) disable iff (rst)
    (pop && pop_data.op != CMD_LOAD) |=> state == S_EVAL)
    else $error("walk command did not reach evaluation");

  a_end_reported: assert property (@(posedge clk) disable iff (rst)
    ($fell(walk_active) && !$past(rst)) |-> (out_valid && out_last))
    else $error("walk ended without a final response");
`endif

endmodule

### src/fat_cluster_chain_walker.sv
// Top level of the FAT cluster chain walker with its APB register file.
//
//   channel    kind        direction  payload
//   request    valid/ready in         cmd, entry_index, entry_value, start_cluster
//   response   valid/ready out        sector_addr, sector_count, status, last
//   apb        psel/pen    in/out     fat_mode, cluster_base, sectors_per_cluster,
//                                     window_sectors at 0x0, 0x4, 0x8, 0xc
//
// A load only writes the link table; a start or advance also passes through the
// synchronous read of the link table before the link is checked.
// A request is accepted whenever the two-entry queue has room.
// The response register holds a result until taken; the engine stalls
// only when a new result is ready and that register is still full.
// Reset is synchronous; the link table is not cleared.
module fat_cluster_chain_walker #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  fccw_req_if.sink    request,
  fccw_rsp_if.source  response,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fccw_pkg::*;

  cfg_t         cfg;
  logic         push;
  queue_entry_t push_data;
  logic         pop;
  queue_entry_t pop_data;
  logic         full;
  logic         empty;
  logic         cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_mode <= 1'b1;
      cfg.cluster_base <= '0;
      cfg.sectors_per_cluster <= 8'd1;
      cfg.window_sectors <= 11'd1024;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_FAT_MODE: cfg.fat_mode <= pwdata[0];
        REG_CLUSTER_BASE: cfg.cluster_base <= pwdata;
        REG_SECTORS: cfg.sectors_per_cluster <= pwdata[7:0];
        REG_WINDOW: cfg.window_sectors <= pwdata[10:0];
        default: cfg.fat_mode <= cfg.fat_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FAT_MODE: prdata = {31'b0, cfg.fat_mode};
      REG_CLUSTER_BASE: prdata = cfg.cluster_base;
      REG_SECTORS: prdata = {24'b0, cfg.sectors_per_cluster};
      REG_WINDOW: prdata = {21'b0, cfg.window_sectors};
      default: prdata = '0;
    endcase
  end

  fccw_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .request   (request),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  fccw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  fccw_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .response (response)
  );

endmodule
